@@ rtl/rv32_pkg.sv @@
// ---------------------------------------------------------------------------
// rv32_pkg: shared types and constants
// Opcodes, result codes, controller states and the command/status bundles
// that join the controller and the datapath.
// ---------------------------------------------------------------------------
`default_nettype none

package rv32_pkg;

	localparam logic [6:0] OPC_OP     = 7'h33;
	localparam logic [6:0] OPC_OP_IMM = 7'h13;
	localparam logic [6:0] OPC_LOAD   = 7'h03;
	localparam logic [6:0] OPC_STORE  = 7'h23;
	localparam logic [6:0] OPC_BRANCH = 7'h63;
	localparam logic [6:0] OPC_LUI    = 7'h37;
	localparam logic [6:0] OPC_AUIPC  = 7'h17;
	localparam logic [6:0] OPC_JAL    = 7'h6f;
	localparam logic [6:0] OPC_JALR   = 7'h67;
	localparam logic [6:0] OPC_SYSTEM = 7'h73;

	localparam logic [31:0] ECALL_WORD = 32'h0000_0073;

	localparam logic [6:0] F7_BASE = 7'h00;
	localparam logic [6:0] F7_ALT  = 7'h20;
	localparam logic [6:0] F7_MULD = 7'h01;

	localparam logic [2:0] F3_ADD  = 3'd0;
	localparam logic [2:0] F3_SLL  = 3'd1;
	localparam logic [2:0] F3_SLT  = 3'd2;
	localparam logic [2:0] F3_XOR  = 3'd4;
	localparam logic [2:0] F3_SR   = 3'd5;
	localparam logic [2:0] F3_OR   = 3'd6;
	localparam logic [2:0] F3_AND  = 3'd7;
	localparam logic [2:0] F3_MUL  = 3'd0;
	localparam logic [2:0] F3_MULH = 3'd1;
	localparam logic [2:0] F3_DIV  = 3'd4;
	localparam logic [2:0] F3_REM  = 3'd6;
	localparam logic [2:0] F3_BYTE = 3'd0;
	localparam logic [2:0] F3_HALF = 3'd1;
	localparam logic [2:0] F3_WORD = 3'd2;
	localparam logic [2:0] F3_BEQ  = 3'd0;
	localparam logic [2:0] F3_BNE  = 3'd1;

	localparam logic [4:0] REG_A0 = 5'd10;
	localparam logic [4:0] REG_A1 = 5'd11;

	localparam logic [31:0] ECALL_PRINT = 32'd1;
	localparam logic [31:0] ECALL_EXIT  = 32'd10;

	localparam logic [2:0] ST_DONE      = 3'd0;
	localparam logic [2:0] ST_PRINT     = 3'd1;
	localparam logic [2:0] ST_EXIT      = 3'd2;
	localparam logic [2:0] ST_BAD_INSTR = 3'd3;
	localparam logic [2:0] ST_BAD_ECALL = 3'd4;
	localparam logic [2:0] ST_BAD_READ  = 3'd5;
	localparam logic [2:0] ST_BAD_WRITE = 3'd6;
	localparam logic [2:0] ST_HALTED    = 3'd7;

	typedef enum logic [2:0] {
		KIND_SIMPLE,
		KIND_LOAD,
		KIND_STORE,
		KIND_MUL,
		KIND_DIV
	} kind_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_READ,
		S_EXEC,
		S_LOAD,
		S_STORE,
		S_MUL,
		S_DIV,
		S_DIVEND,
		S_COMMIT
	} ctrl_state_t;

	typedef struct packed {
		logic accept;
		logic read;
		logic exec;
		logic load_fin;
		logic store_wr;
		logic mul_fin;
		logic div_step;
		logic div_fin;
		logic commit;
	} dp_cmd_t;

	typedef struct packed {
		logic  skip;
		kind_t kind;
		logic  div_last;
	} dp_stat_t;

endpackage

`default_nettype wire

@@ rtl/rv32_ctrl.sv @@
// ---------------------------------------------------------------------------
// rv32_ctrl: sequencing controller
// Steps each request through operand read, execute, memory, multiply or
// divide, and commit (skipped ones go straight to commit); owns out_valid.
// ---------------------------------------------------------------------------
`default_nettype none

module rv32_ctrl import rv32_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	output logic          in_stall,
	output logic          out_valid,
	input  wire logic     out_stall,
	input  wire dp_stat_t stat,
	output dp_cmd_t       cmd
);

	ctrl_state_t state_q, state_d;
	logic        out_valid_q;
	logic        out_free;

	assign out_free  = !out_valid_q || !out_stall;
	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.commit)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_d    = stat.skip ? S_COMMIT : S_READ;
				end
			end
			S_READ: begin
				cmd.read = 1'b1;
				state_d  = S_EXEC;
			end
			S_EXEC: begin
				cmd.exec = 1'b1;
				unique case (stat.kind)
					KIND_LOAD:  state_d = S_LOAD;
					KIND_STORE: state_d = S_STORE;
					KIND_MUL:   state_d = S_MUL;
					KIND_DIV:   state_d = S_DIV;
					default:    state_d = S_COMMIT;
				endcase
			end
			S_LOAD: begin
				cmd.load_fin = 1'b1;
				state_d      = S_COMMIT;
			end
			S_STORE: begin
				cmd.store_wr = 1'b1;
				state_d      = S_COMMIT;
			end
			S_MUL: begin
				cmd.mul_fin = 1'b1;
				state_d     = S_COMMIT;
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (stat.div_last)
					state_d = S_DIVEND;
			end
			S_DIVEND: begin
				cmd.div_fin = 1'b1;
				state_d     = S_COMMIT;
			end
			S_COMMIT: begin
				if (out_free) begin
					cmd.commit = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

endmodule

`default_nettype wire

@@ rtl/rv32_dpath.sv @@
// ---------------------------------------------------------------------------
// rv32_dpath: execution datapath
// Register file, program counter, data memory, decode and ALU, multiplier,
// radix-2 divider and the registered result.
// ---------------------------------------------------------------------------
`default_nettype none

module rv32_dpath import rv32_pkg::*; #(
	parameter int MEM_BYTES = 65536
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire dp_cmd_t     cmd,
	output dp_stat_t         stat,
	input  wire logic        command,
	input  wire logic [31:0] instr_word,
	input  wire logic [13:0] preload_index,
	input  wire logic [31:0] preload_data,
	output logic [2:0]       status,
	output logic [31:0]      next_pc,
	output logic [4:0]       dest_index,
	output logic [31:0]      dest_value,
	output logic             dest_written,
	output logic signed [31:0] print_value
);

	localparam int MEM_WORDS = (MEM_BYTES + 3) / 4;
	localparam int AW = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;
	localparam logic [32:0] MEM_LIMIT = 33'(MEM_BYTES);
	localparam logic [31:0] MEM_WORDS_W = 32'(MEM_WORDS);

	// architectural state
	logic [31:0] rf_mem [32];
	logic [31:0] rf_vld_q;
	logic [31:0] pc_q;
	logic        halted_q;
	logic [31:0] dmem [MEM_WORDS];

	logic [31:0] instr_q;
	logic [31:0] rf_a_q, rf_b_q;
	logic [31:0] dm_rdata_q;
	logic [2:0]  res_status_q;
	logic [31:0] res_val_q, res_npc_q, res_pv_q, addr_q;
	logic        res_wr_q;
	logic [63:0] prod_q;
	logic [31:0] quo_q, rem_q, dvs_q;
	logic [4:0]  cnt_q;

	logic [2:0]  out_status_q;
	logic [31:0] out_npc_q, out_val_q, out_pv_q;
	logic [4:0]  out_idx_q;
	logic        out_wr_q;

	// instruction fields
	logic [6:0]  opc, f7;
	logic [2:0]  f3;
	logic [4:0]  rd, ra, rb;
	logic [31:0] imm_i, imm_s, imm_b, imm_u, imm_j;

	assign opc   = instr_q[6:0];
	assign f3    = instr_q[14:12];
	assign f7    = instr_q[31:25];
	assign rd    = instr_q[11:7];
	assign imm_i = {{20{instr_q[31]}}, instr_q[31:20]};
	assign imm_s = {{20{instr_q[31]}}, instr_q[31:25], instr_q[11:7]};
	assign imm_b = {{20{instr_q[31]}}, instr_q[7], instr_q[30:25], instr_q[11:8], 1'b0};
	assign imm_u = {instr_q[31:12], 12'b0};
	assign imm_j = {{12{instr_q[31]}}, instr_q[19:12], instr_q[20], instr_q[30:21], 1'b0};

	// ecall reads a0/a1 through the same ports
	assign ra = (opc == OPC_SYSTEM) ? REG_A0 : instr_q[19:15];
	assign rb = (opc == OPC_SYSTEM) ? REG_A1 : instr_q[24:20];

	// ---------------- execute ----------------
	logic [2:0]  ex_status;
	logic [31:0] ex_val, ex_npc, ex_pv, ex_addr, pc4;
	logic        ex_wr, ex_ok, mem_ok;
	kind_t       ex_kind;
	logic [2:0]  acc_size;
	logic [32:0] acc_end;
	logic        misalign;
	logic signed [63:0] mul_full;

	assign pc4      = pc_q + 32'd4;
	assign ex_addr  = rf_a_q + ((opc == OPC_STORE) ? imm_s : imm_i);
	assign acc_size = f3[1] ? 3'd4 : (f3[0] ? 3'd2 : 3'd1);
	assign acc_end  = {1'b0, ex_addr} + {30'b0, acc_size};
	assign misalign = ((f3 == F3_HALF) && ex_addr[0]) ||
	                  ((f3 == F3_WORD) && (ex_addr[1:0] != 2'b00));
	assign mem_ok   = (ex_addr != 32'd0) && (acc_end <= MEM_LIMIT) && !misalign;
	assign mul_full = $signed(rf_a_q) * $signed(rf_b_q);

	always_comb begin
		ex_status = ST_DONE;
		ex_val    = 32'd0;
		ex_npc    = pc4;
		ex_pv     = 32'd0;
		ex_wr     = 1'b0;
		ex_ok     = 1'b1;
		ex_kind   = KIND_SIMPLE;
		unique case (opc)
			OPC_OP: begin
				ex_wr = 1'b1;
				case (f7)
					F7_BASE: begin
						case (f3)
							F3_ADD: ex_val = rf_a_q + rf_b_q;
							F3_SLL: ex_val = rf_a_q << rf_b_q[4:0];
							F3_SLT: ex_val = {31'b0, $signed(rf_a_q) < $signed(rf_b_q)};
							F3_XOR: ex_val = rf_a_q ^ rf_b_q;
							F3_SR:  ex_val = rf_a_q >> rf_b_q[4:0];
							F3_OR:  ex_val = rf_a_q | rf_b_q;
							F3_AND: ex_val = rf_a_q & rf_b_q;
							default: ex_ok = 1'b0;
						endcase
					end
					F7_ALT: begin
						case (f3)
							F3_ADD: ex_val = rf_a_q - rf_b_q;
							F3_SR:  ex_val = 32'($signed(rf_a_q) >>> rf_b_q[4:0]);
							default: ex_ok = 1'b0;
						endcase
					end
					F7_MULD: begin
						case (f3)
							F3_MUL, F3_MULH: ex_kind = KIND_MUL;
							F3_DIV, F3_REM:  ex_kind = KIND_DIV;
							default:         ex_ok = 1'b0;
						endcase
					end
					default: ex_ok = 1'b0;
				endcase
			end
			OPC_OP_IMM: begin
				ex_wr = 1'b1;
				case (f3)
					F3_ADD: ex_val = rf_a_q + imm_i;
					F3_SLL: begin
						if (f7 == F7_BASE) ex_val = rf_a_q << instr_q[24:20];
						else ex_ok = 1'b0;
					end
					F3_SLT: ex_val = {31'b0, $signed(rf_a_q) < $signed(imm_i)};
					F3_XOR: ex_val = rf_a_q ^ imm_i;
					F3_SR: begin
						if (f7 == F7_BASE) ex_val = rf_a_q >> instr_q[24:20];
						else if (f7 == F7_ALT)
							ex_val = 32'($signed(rf_a_q) >>> instr_q[24:20]);
						else ex_ok = 1'b0;
					end
					F3_OR:  ex_val = rf_a_q | imm_i;
					F3_AND: ex_val = rf_a_q & imm_i;
					default: ex_ok = 1'b0;
				endcase
			end
			OPC_LOAD: begin
				if (f3 > F3_WORD) ex_ok = 1'b0;
				else if (!mem_ok) ex_status = ST_BAD_READ;
				else begin
					ex_kind = KIND_LOAD;
					ex_wr   = 1'b1;
				end
			end
			OPC_STORE: begin
				if (f3 > F3_WORD) ex_ok = 1'b0;
				else if (!mem_ok) ex_status = ST_BAD_WRITE;
				else ex_kind = KIND_STORE;
			end
			OPC_BRANCH: begin
				if (f3 > F3_BNE) ex_ok = 1'b0;
				else if ((rf_a_q == rf_b_q) == (f3 == F3_BEQ)) ex_npc = pc_q + imm_b;
			end
			OPC_LUI: begin
				ex_val = imm_u;
				ex_wr  = 1'b1;
			end
			OPC_AUIPC: begin
				ex_val = pc_q + imm_u;
				ex_wr  = 1'b1;
			end
			OPC_JAL: begin
				ex_val = pc4;
				ex_wr  = 1'b1;
				ex_npc = pc_q + imm_j;
			end
			OPC_JALR: begin
				if (f3 != F3_ADD) ex_ok = 1'b0;
				else begin
					ex_val = pc4;
					ex_wr  = 1'b1;
					ex_npc = (rf_a_q + imm_i) & ~32'd1;
				end
			end
			OPC_SYSTEM: begin
				if (instr_q != ECALL_WORD) ex_ok = 1'b0;
				else if (rf_a_q == ECALL_PRINT) begin
					ex_status = ST_PRINT;
					ex_pv     = rf_b_q;
				end else if (rf_a_q == ECALL_EXIT) ex_status = ST_EXIT;
				else ex_status = ST_BAD_ECALL;
			end
			default: ex_ok = 1'b0;
		endcase
		if (!ex_ok)
			ex_status = ST_BAD_INSTR;
		// a fault or exit leaves everything in place
		if (ex_status != ST_DONE && ex_status != ST_PRINT) begin
			ex_wr   = 1'b0;
			ex_pv   = 32'd0;
			ex_npc  = pc_q;
			ex_kind = KIND_SIMPLE;
		end
	end

	// ---------------- divider ----------------
	logic [32:0] div_trial;
	logic        a_neg, b_neg;
	logic [31:0] a_mag, b_mag, div_res;

	assign a_neg     = rf_a_q[31];
	assign b_neg     = rf_b_q[31];
	assign a_mag     = a_neg ? (32'd0 - rf_a_q) : rf_a_q;
	assign b_mag     = b_neg ? (32'd0 - rf_b_q) : rf_b_q;
	assign div_trial = {rem_q, quo_q[31]} - {1'b0, dvs_q};

	always_comb begin
		if (rf_b_q == 32'd0)
			div_res = (f3 == F3_REM) ? rf_a_q : 32'hffff_ffff;
		else if (f3 == F3_REM)
			div_res = a_neg ? (32'd0 - rem_q) : rem_q;
		else
			div_res = (a_neg ^ b_neg) ? (32'd0 - quo_q) : quo_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			cnt_q <= '0;
		else if (cmd.exec)
			cnt_q <= 5'd31;
		else if (cmd.div_step)
			cnt_q <= cnt_q - 5'd1;
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			quo_q <= a_mag;
			rem_q <= 32'd0;
			dvs_q <= b_mag;
		end else if (cmd.div_step) begin
			if (!div_trial[32]) begin
				rem_q <= div_trial[31:0];
				quo_q <= {quo_q[30:0], 1'b1};
			end else begin
				rem_q <= {rem_q[30:0], quo_q[31]};
				quo_q <= {quo_q[30:0], 1'b0};
			end
		end
	end

	assign stat.skip     = command || halted_q;
	assign stat.kind     = ex_kind;
	assign stat.div_last = (cnt_q == 5'd0);

	// ---------------- memories ----------------
	logic [31:0] pre_idx32;
	logic        pre_we;
	logic [4:0]  lane_sh;
	logic [31:0] lane_mask, ld_word, st_word;

	assign pre_idx32 = {18'b0, preload_index};
	assign pre_we    = cmd.accept && command && (pre_idx32 < MEM_WORDS_W);
	assign lane_sh   = {addr_q[1:0], 3'b000};
	assign lane_mask = (f3 == F3_BYTE) ? 32'h0000_00ff :
	                   (f3 == F3_HALF) ? 32'h0000_ffff : 32'hffff_ffff;
	assign st_word   = (dm_rdata_q & ~(lane_mask << lane_sh)) |
	                   ((rf_b_q << lane_sh) & (lane_mask << lane_sh));

	always_comb begin
		logic [31:0] w;
		w = dm_rdata_q >> lane_sh;
		case (f3)
			F3_BYTE: ld_word = {{24{w[7]}}, w[7:0]};
			F3_HALF: ld_word = {{16{w[15]}}, w[15:0]};
			default: ld_word = w;
		endcase
	end

	always_ff @(posedge clk) begin
		if (pre_we)
			dmem[pre_idx32[AW-1:0]] <= preload_data;
		else if (cmd.store_wr)
			dmem[addr_q[AW+1:2]] <= st_word;
		if (cmd.exec)
			dm_rdata_q <= dmem[ex_addr[AW+1:2]];
	end

	logic commit_wr;
	assign commit_wr = res_wr_q && (rd != 5'd0) &&
	                   (res_status_q == ST_DONE || res_status_q == ST_PRINT);

	always_ff @(posedge clk) begin
		if (cmd.read) begin
			rf_a_q <= rf_vld_q[ra] ? rf_mem[ra] : 32'd0;
			rf_b_q <= rf_vld_q[rb] ? rf_mem[rb] : 32'd0;
		end
		if (cmd.commit && commit_wr)
			rf_mem[rd] <= res_val_q;
	end

	// ---------------- control state ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rf_vld_q <= '0;
			pc_q     <= '0;
			halted_q <= 1'b0;
		end else if (cmd.commit) begin
			if (res_status_q == ST_DONE || res_status_q == ST_PRINT) begin
				pc_q <= res_npc_q;
				if (commit_wr)
					rf_vld_q[rd] <= 1'b1;
			end else begin
				halted_q <= 1'b1;
			end
		end
	end

	// ---------------- result registers ----------------
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			instr_q      <= instr_word;
			res_status_q <= command ? ST_DONE : ST_HALTED;
			res_npc_q    <= pc_q;
			res_val_q    <= 32'd0;
			res_pv_q     <= 32'd0;
			res_wr_q     <= 1'b0;
		end
		if (cmd.exec) begin
			res_status_q <= ex_status;
			res_npc_q    <= ex_npc;
			res_val_q    <= ex_val;
			res_pv_q     <= ex_pv;
			res_wr_q     <= ex_wr;
			addr_q       <= ex_addr;
			prod_q       <= mul_full;
		end
		if (cmd.load_fin)
			res_val_q <= ld_word;
		if (cmd.mul_fin)
			res_val_q <= (f3 == F3_MUL) ? prod_q[31:0] : prod_q[63:32];
		if (cmd.div_fin)
			res_val_q <= div_res;
		if (cmd.commit) begin
			out_status_q <= res_status_q;
			out_npc_q    <= (res_status_q == ST_DONE || res_status_q == ST_PRINT) ?
			                res_npc_q : pc_q;
			out_wr_q     <= commit_wr;
			out_idx_q    <= commit_wr ? rd : 5'd0;
			out_val_q    <= commit_wr ? res_val_q : 32'd0;
			out_pv_q     <= res_pv_q;
		end
	end

	assign status       = out_status_q;
	assign next_pc      = out_npc_q;
	assign dest_index   = out_idx_q;
	assign dest_value   = out_val_q;
	assign dest_written = out_wr_q;
	assign print_value  = out_pv_q;

endmodule

`default_nettype wire

@@ rtl/rv32im_instruction_execute.sv @@
// ---------------------------------------------------------------------------
// rv32im_instruction_execute: RV32IM-subset instruction executor
// Runs one instruction, or preloads one data word, per request.
// ---------------------------------------------------------------------------
// Each request either executes instr_word against the 32-entry register file
// and the program counter, or (command high) writes preload_data into data
// memory word preload_index; a preload beyond the memory depth is dropped.
// One request is in flight at a time and each gives exactly one result.
// A preload, or any instruction once halted, goes straight to commit; ALU,
// branch, jump, upper-immediate and ecall commit after execute; loads,
// stores, mul and mulh pass a memory or multiply state first, and div and
// rem run the radix-2 divider, which retires one quotient bit a cycle.
// The next request is taken once the result is in the output register,
// even while that result is still stalled. Data memory needs no clearing
// after reset: a word must be preloaded or stored before it is loaded.
// A fault (bad instruction, bad ecall, bad read, bad write) or an exit
// ecall halts the core until reset; the program counter then stays on the
// instruction that stopped it. Addresses are checked for range, alignment
// and a zero address against MEM_BYTES.
// ---------------------------------------------------------------------------
`default_nettype none

module rv32im_instruction_execute import rv32_pkg::*; #(
	parameter int MEM_BYTES = 65536
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// request channel
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic        command,
	input  wire logic [31:0] instr_word,
	input  wire logic [13:0] preload_index,
	input  wire logic [31:0] preload_data,
	// result channel
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [2:0]       status,
	output logic [31:0]      next_pc,
	output logic [4:0]       dest_index,
	output logic [31:0]      dest_value,
	output logic             dest_written,
	output logic signed [31:0] print_value
);

	// commands from the sequencer, status back from the datapath
	dp_cmd_t  cmd;
	dp_stat_t stat;

	rv32_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	// register file, memory, ALU, multiplier and divider
	rv32_dpath #(
		.MEM_BYTES (MEM_BYTES)
	) u_dpath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.command       (command),
		.instr_word    (instr_word),
		.preload_index (preload_index),
		.preload_data  (preload_data),
		.status        (status),
		.next_pc       (next_pc),
		.dest_index    (dest_index),
		.dest_value    (dest_value),
		.dest_written  (dest_written),
		.print_value   (print_value)
	);

endmodule

`default_nettype wire
